// ===== sv/ffha_pkg.sv =====
`default_nettype none
package ffha_pkg;
    localparam int ArenaBytesDef  = 1024;
    localparam int AlignBytesDef  = 16;
    localparam int HeaderBytesDef = 16;
    localparam int MaxSegmentsDef = 32;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOFIT   = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef struct packed {
        logic       command;
        logic [9:0] request_size;
        logic [9:0] free_offset;
    } t_in_beat;

    typedef struct packed {
        logic [9:0] payload_offset;
        logic [1:0] status;
    } t_out_beat;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SPLIT_RD,
        S_SPLIT_WR,
        S_SPLIT_NEW,
        S_MERGE_LD,
        S_MERGE_RD,
        S_MERGE_CHK,
        S_MERGE_MOVE,
        S_DONE
    } t_state;
endpackage
`default_nettype wire

// ===== sv/ffha_seg_mem.sv =====
`default_nettype none
// Segment table storage: start, size, used per entry; one write port,
// one registered read port.
module ffha_seg_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 16,
    parameter int IW    = 5
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [IW-1:0] i_waddr,
    input  wire logic [AW-1:0] i_wstart,
    input  wire logic [AW-1:0] i_wsize,
    input  wire logic          i_wused,
    input  wire logic [IW-1:0] i_raddr,
    output logic      [AW-1:0] o_rstart,
    output logic      [AW-1:0] o_rsize,
    output logic               o_rused
);
    logic [2*AW:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= {i_wstart, i_wsize, i_wused};
        end
        {o_rstart, o_rsize, o_rused} <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== sv/first_fit_heap_allocator.sv =====
`default_nettype none
// First-fit heap allocator with coalescing.
// Input channel (i_in_valid/o_in_ready, i_in_data): one beat is a command,
// allocate (request_size) or free (free_offset). Output channel
// (o_out_valid/i_out_ready, o_out_data): exactly one result beat per input
// beat: payload offset and status (ok, no fit, unknown offset).
// The segment table lives in a memory with one registered read port, walked
// by one sequencer with one shared adder/comparator. A scan step is a read
// state followed by a check state for each segment. An allocate is accepted,
// scans, and on a split shifts the later entries up one place and writes
// the new free entry. A free scans, reloads entry 0 unless the freed entry
// is entry 0, then sweeps the adjacent pairs, merging two free neighbours
// and moving the later entries down one place on each merge.
// One item is in flight at a time: o_in_ready is high only when idle. The
// result is held in the done state until taken; a stalled receiver keeps the
// block waiting there and o_in_ready low.
// Reset (synchronous, active low) sets the table to one free segment of
// the whole arena; no clearing pass is needed (entry 0 reads as its reset
// value until first written, other entries are only used below the count).
module first_fit_heap_allocator #(
    parameter int ARENA_BYTES  = ffha_pkg::ArenaBytesDef,
    parameter int ALIGN_BYTES  = ffha_pkg::AlignBytesDef,
    parameter int HEADER_BYTES = ffha_pkg::HeaderBytesDef,
    parameter int MAX_SEGMENTS = ffha_pkg::MaxSegmentsDef
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire ffha_pkg::t_in_beat  i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output ffha_pkg::t_out_beat      o_out_data
);
    import ffha_pkg::*;

    localparam int AW = $clog2(ARENA_BYTES) + 1;
    localparam int IW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int LA = $clog2(ALIGN_BYTES);
    localparam logic [AW-1:0] HDR  = AW'(HEADER_BYTES);
    localparam logic [AW-1:0] ALN  = AW'(ALIGN_BYTES);
    localparam logic [AW-1:0] SZ0  = AW'(ARENA_BYTES - HEADER_BYTES);
    localparam logic [CW-1:0] CMAX = CW'(MAX_SEGMENTS);

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;     // scan / merge position
    logic [CW-1:0] r_j, n_j;         // shift cursor
    logic          r_cmd;
    logic [AW-1:0] r_pad;
    logic [9:0]    r_foff;
    logic [AW-1:0] r_hs, n_hs;       // held segment start
    logic [AW-1:0] r_hz, n_hz;       // held segment size
    logic          r_hu, n_hu;
    logic [9:0]    r_off, n_off;
    logic [1:0]    r_st, n_st;
    logic          r_init;           // entry 0 not yet written since reset

    logic          we;
    logic [IW-1:0] waddr, raddr;
    logic [AW-1:0] wstart, wsize;
    logic          wused;
    logic [AW-1:0] m_start, m_size;
    logic          m_used;
    logic [AW-1:0] rd_start, rd_size;
    logic          rd_used;
    logic          r_rd0;

    ffha_seg_mem #(.DEPTH(MAX_SEGMENTS), .AW(AW), .IW(IW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wstart(wstart),
        .i_wsize (wsize),
        .i_wused (wused),
        .i_raddr (raddr),
        .o_rstart(m_start),
        .o_rsize (m_size),
        .o_rused (m_used)
    );

    // Entry 0 reads as its reset value until first written.
    always_comb begin
        if (r_init && r_rd0) begin
            rd_start = '0;
            rd_size  = SZ0;
            rd_used  = 1'b0;
        end else begin
            rd_start = m_start;
            rd_size  = m_size;
            rd_used  = m_used;
        end
    end

    // Shared adder / comparator
    logic [AW:0] sum;
    logic [AW-1:0] add_a, add_b;
    always_comb begin
        add_a = rd_start;
        add_b = HDR;
        unique case (r_state)
            S_SCAN_CHK: begin
                if (r_cmd == CMD_ALLOC) begin
                    add_a = r_pad;
                    add_b = HDR + ALN;
                end
            end
            S_SPLIT_NEW: begin add_a = r_hs; add_b = HDR + r_pad; end
            S_MERGE_CHK: begin add_a = r_hz; add_b = rd_size + HDR; end
            default: ;
        endcase
        sum = {1'b0, add_a} + {1'b0, add_b};
    end

    // split leaves at least a header plus one alignment unit; table not full
    wire split_ok = ({1'b0, rd_size} >= sum) && (r_count < CMAX);
    wire free_hit = (sum == (AW+1)'(r_foff));

    wire [AW-1:0] pad_in = AW'(((AW+1)'(i_in_data.request_size) + (AW+1)'(ALIGN_BYTES - 1))
                               >> LA) << LA;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:      if (i_in_valid) n_state = S_SCAN_RD;
            S_SCAN_RD:   n_state = (r_idx < r_count) ? S_SCAN_CHK : S_DONE;
            S_SCAN_CHK: begin
                if (r_cmd == CMD_ALLOC) begin
                    if (!rd_used && rd_size >= r_pad) begin
                        n_state = split_ok ? S_SPLIT_RD : S_DONE;
                    end else n_state = S_SCAN_RD;
                end else if (free_hit) begin
                    n_state = (r_idx == '0) ? S_MERGE_RD : S_MERGE_LD;
                end else n_state = S_SCAN_RD;
            end
            S_SPLIT_RD:  n_state = (r_j > r_idx + 1'b1) ? S_SPLIT_WR : S_SPLIT_NEW;
            S_SPLIT_WR:  n_state = S_SPLIT_RD;
            S_SPLIT_NEW: n_state = S_DONE;
            S_MERGE_LD:  n_state = S_MERGE_RD;
            S_MERGE_RD:  n_state = (r_idx + 1'b1 < r_count) ? S_MERGE_CHK : S_DONE;
            S_MERGE_CHK: n_state = (!r_hu && !rd_used) ? S_MERGE_MOVE : S_MERGE_RD;
            S_MERGE_MOVE: n_state = (r_j + 1'b1 < r_count) ? S_MERGE_MOVE : S_MERGE_RD;
            S_DONE:      if (i_out_ready) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_count = r_count; n_idx = r_idx; n_j = r_j;
        n_hs = r_hs; n_hz = r_hz; n_hu = r_hu; n_off = r_off; n_st = r_st;
        we = 1'b0; waddr = '0; wstart = r_hs; wsize = r_hz; wused = r_hu;
        raddr = r_idx[IW-1:0];
        unique case (r_state)
            S_IDLE: begin
                n_idx = '0; n_off = '0;
                n_st = (i_in_data.command == CMD_ALLOC) ? ST_NOFIT : ST_UNKNOWN;
                raddr = '0;
            end
            S_SCAN_RD: raddr = r_idx[IW-1:0];
            S_SCAN_CHK: begin
                n_hs = rd_start; n_hz = rd_size; n_hu = rd_used;
                if (r_cmd == CMD_ALLOC) begin
                    if (!rd_used && rd_size >= r_pad) begin
                        n_st = ST_OK;
                        n_off = 10'(rd_start + HDR);
                        n_hu = 1'b1;
                        we = 1'b1; waddr = r_idx[IW-1:0];
                        wstart = rd_start; wsize = rd_size; wused = 1'b1;
                        n_j = r_count;
                        if (split_ok) wsize = r_pad;
                    end else n_idx = r_idx + 1'b1;
                end else if (free_hit) begin
                    // freed entry held directly when it is entry 0,
                    // otherwise entry 0 is fetched for the merge sweep
                    n_st = ST_OK;
                    n_hu = 1'b0;
                    we = 1'b1; waddr = r_idx[IW-1:0];
                    wstart = rd_start; wsize = rd_size; wused = 1'b0;
                    n_idx = '0;
                    raddr = '0;
                end else n_idx = r_idx + 1'b1;
            end
            S_SPLIT_RD: raddr = IW'(r_j - 1'b1);
            S_SPLIT_WR: begin
                we = 1'b1; waddr = r_j[IW-1:0];
                wstart = rd_start; wsize = rd_size; wused = rd_used;
                n_j = r_j - 1'b1;
            end
            S_SPLIT_NEW: begin
                we = 1'b1; waddr = IW'(r_idx + 1'b1);
                wstart = sum[AW-1:0];
                wsize = r_hz - HDR - r_pad; wused = 1'b0;
                n_count = r_count + 1'b1;
            end
            S_MERGE_LD: begin
                n_hs = rd_start; n_hz = rd_size; n_hu = rd_used;
            end
            S_MERGE_RD: begin
                // hold entry idx, fetch idx+1
                raddr = IW'(r_idx + 1'b1);
            end
            S_MERGE_CHK: begin
                if (!r_hu && !rd_used) begin
                    n_hz = sum[AW-1:0];
                    we = 1'b1; waddr = r_idx[IW-1:0];
                    wstart = r_hs; wsize = sum[AW-1:0]; wused = 1'b0;
                    n_j = r_idx + 1'b1;
                    raddr = IW'(r_idx + 2'd2);
                end else begin
                    n_idx = r_idx + 1'b1;
                    n_hs = rd_start; n_hz = rd_size; n_hu = rd_used;
                end
            end
            S_MERGE_MOVE: begin
                // copy entry j+1 (just read) down to j, fetch the next one
                if (r_j + 1'b1 < r_count) begin
                    we = 1'b1; waddr = r_j[IW-1:0];
                    wstart = rd_start; wsize = rd_size; wused = rd_used;
                    n_j = r_j + 1'b1;
                    raddr = IW'(r_j + 2'd2);
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= CW'(1);
            r_init  <= 1'b1;
            r_rd0   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_rd0   <= (raddr == '0);
            if (we && waddr == '0) r_init <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx; r_j <= n_j;
        r_hs <= n_hs; r_hz <= n_hz; r_hu <= n_hu;
        r_off <= n_off; r_st <= n_st;
        if (r_state == S_IDLE) begin
            r_cmd  <= i_in_data.command;
            r_pad  <= pad_in;
            r_foff <= i_in_data.free_offset;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_DONE);
    assign o_out_data.payload_offset = (r_st == ST_OK) ? r_off : 10'd0;
    assign o_out_data.status = r_st;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count >= CW'(1) && r_count <= CMAX) else $error("segment count out of range");
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid)) else $error("ready while result pending");
    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid) else $error("result dropped");
endmodule
`default_nettype wire
